FILE: hw/rtl/xm1k_pkg.sv
// xm1k_pkg: shared types, constants and the crc-16 step for the xmodem-1k sender
// no dependencies; imported by the sender top level and its checker

package xm1k_pkg;

  // defaults for the top-level parameters
  localparam int unsigned BlockBytesDef = 1024;
  localparam int unsigned AddrBitsDef   = 24;

  // fixed field and state widths
  localparam int unsigned FileSizeW = 24;
  localparam int unsigned FetchW    = 24;
  localparam int unsigned BlockNumW = 15;
  localparam int unsigned CrcW      = 16;

  // result queue geometry
  localparam int unsigned MaxRes    = 3;
  localparam int unsigned QueDepth  = 4;
  localparam int unsigned QuePtrW   = 2;
  localparam int unsigned QueCntW   = 3;

  // protocol characters
  localparam logic [7:0] ChStx   = 8'h02;
  localparam logic [7:0] ChEot   = 8'h04;
  localparam logic [7:0] ChAck   = 8'h06;
  localparam logic [7:0] ChNak   = 8'h15;
  localparam logic [7:0] ChCan   = 8'h18;
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] PadByte = 8'h1A;

  localparam logic [CrcW-1:0] CrcPoly = 16'h1021;

  // event codes
  localparam logic [1:0] EvNone  = 2'd0;
  localparam logic [1:0] EvEot   = 2'd1;
  localparam logic [1:0] EvAbort = 2'd2;

  // input word kinds
  localparam logic ActCtrl = 1'b0;
  localparam logic ActData = 1'b1;

  typedef enum logic [1:0] {
    PhWait = 2'b01,
    PhSend = 2'b10
  } phase_e;

  typedef struct packed {
    logic       action;
    logic [7:0] in_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]        tx_byte;
    logic              tx_valid;
    logic              fetch_valid;
    logic [FetchW-1:0] fetch_address;
    logic [1:0]        event_code;
    logic              last;
  } out_word_t;

  // one byte through the crc-16 (msb first, no reflection)
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [7:0]      b);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[CrcW-1] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/xmodem_1k_crc_sender_top.sv
// xmodem_1k_crc_sender_top: xmodem-1k crc sender, control and result queue
// depends on xm1k_pkg
// the results of a word are written into the result queue and offered from there
// throughput: one word per cycle while each gives one result and the output drains;
//   a word giving three results holds off the input until at most one result waits (queue of four)
// reset: asynchronous active low; clears phase, counters, crc, abort flag, file_size

module xmodem_1k_crc_sender_top #(
  parameter int unsigned BLOCK_BYTES = xm1k_pkg::BlockBytesDef,
  parameter int unsigned ADDR_BITS   = xm1k_pkg::AddrBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // receiver control bytes and fetched image bytes
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  xm1k_pkg::in_word_t                 in_word_i,
  // transmit bytes, fetch requests and events
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output xm1k_pkg::out_word_t                out_word_o,
  // file size register
  input  logic                               cfg_we_i,
  input  logic [xm1k_pkg::FileSizeW-1:0]     cfg_data_i
);

  import xm1k_pkg::*;

  // offset within a block, and a byte position wide enough for any block
  localparam int unsigned OffW = $clog2(BLOCK_BYTES);
  localparam int unsigned PosW = BlockNumW + OffW + 1;
  localparam int unsigned CmpW = (PosW > FileSizeW) ? PosW : FileSizeW;

  // ---------------------------------------------------------------------------
  // transfer state
  // ---------------------------------------------------------------------------
  logic [FileSizeW-1:0] file_size_q;
  phase_e               phase_q, phase_d;
  logic [BlockNumW-1:0] bn_q, bn_d;
  logic [OffW-1:0]      off_q, off_d;
  logic [CrcW-1:0]      crc_q, crc_d;
  logic                 abort_q, abort_d;

  // result queue: up to three results written per word, one read per cycle while the output is ready
  out_word_t            que_q [QueDepth];
  logic [QuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueCntW-1:0]   cnt_q, cnt_d;

  logic                 in_fire, out_fire;
  out_word_t            res [MaxRes];
  logic [1:0]           n_res;

  // data path for a fetched byte
  logic [PosW-1:0]      pos;
  logic                 pos_in_file;
  logic [7:0]           data_byte;
  logic [CrcW-1:0]      crc_next;
  logic                 block_end;
  logic [ADDR_BITS-1:0] next_addr;

  // block start
  logic [BlockNumW-1:0] bn_sel;
  logic                 do_start;
  logic [PosW-1:0]      base;
  logic [ADDR_BITS-1:0] base_addr;
  logic [7:0]           num_byte;

  // ready while at most one result waits, so three more always fit
  assign in_ready_o  = (cnt_q <= QueCntW'(1));
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_fire    = out_valid_o & out_ready_i;
  assign out_word_o  = que_q[rd_ptr_q];

  // position of the byte now arriving, padding past the end of the file
  assign pos         = PosW'(bn_q) * PosW'(BLOCK_BYTES) + PosW'(off_q);
  assign pos_in_file = CmpW'(pos) < CmpW'(file_size_q);
  assign data_byte   = pos_in_file ? in_word_i.in_byte : PadByte;
  assign crc_next    = crc_byte(crc_q, data_byte);
  assign block_end   = (off_q >= OffW'(BLOCK_BYTES - 1));
  assign next_addr   = ADDR_BITS'(pos + PosW'(1));

  always_comb begin
    phase_d  = phase_q;
    bn_d     = bn_q;
    off_d    = off_q;
    crc_d    = crc_q;
    abort_d  = abort_q;
    n_res    = '0;
    bn_sel   = bn_q;
    do_start = 1'b0;
    for (int k = 0; k < MaxRes; k++) begin
      res[k] = '0;
    end

    if (in_fire) begin
      if (in_word_i.action == ActCtrl) begin
        // control bytes count only between blocks
        if (phase_q == PhWait) begin
          unique case (in_word_i.in_byte)
            ChC: begin
              bn_sel   = '0;
              abort_d  = 1'b0;
              do_start = 1'b1;
            end
            ChAck: begin
              if (!abort_q) begin
                bn_sel   = bn_q + BlockNumW'(1);
                do_start = 1'b1;
              end
            end
            ChNak: begin
              if (!abort_q) begin
                do_start = 1'b1;
              end
            end
            ChCan: begin
              abort_d           = 1'b1;
              res[0].event_code = EvAbort;
              res[0].last       = 1'b1;
              n_res             = 2'd1;
            end
            default: ;
          endcase
        end
      end else if (phase_q == PhSend) begin
        crc_d            = crc_next;
        res[0].tx_byte   = data_byte;
        res[0].tx_valid  = 1'b1;
        if (block_end) begin
          // last data byte, then the crc high byte first
          phase_d          = PhWait;
          off_d            = '0;
          res[1].tx_byte   = crc_next[15:8];
          res[1].tx_valid  = 1'b1;
          res[2].tx_byte   = crc_next[7:0];
          res[2].tx_valid  = 1'b1;
          res[2].last      = 1'b1;
          n_res            = 2'd3;
        end else begin
          off_d                 = off_q + OffW'(1);
          res[0].fetch_valid    = 1'b1;
          res[0].fetch_address  = FetchW'(next_addr);
          res[0].last           = 1'b1;
          n_res                 = 2'd1;
        end
      end
    end

    // new block or end of transmission
    base      = PosW'(bn_sel) * PosW'(BLOCK_BYTES);
    base_addr = ADDR_BITS'(base);
    num_byte  = bn_sel[7:0];
    if (do_start) begin
      bn_d = bn_sel;
      if (CmpW'(base) < CmpW'(file_size_q)) begin
        phase_d              = PhSend;
        off_d                = '0;
        crc_d                = '0;
        res[0].tx_byte       = ChStx;
        res[0].tx_valid      = 1'b1;
        res[1].tx_byte       = num_byte;
        res[1].tx_valid      = 1'b1;
        res[2].tx_byte       = ~num_byte;
        res[2].tx_valid      = 1'b1;
        res[2].fetch_valid   = 1'b1;
        res[2].fetch_address = FetchW'(base_addr);
        res[2].last          = 1'b1;
        n_res                = 2'd3;
      end else begin
        res[0].tx_byte    = ChEot;
        res[0].tx_valid   = 1'b1;
        res[0].event_code = EvEot;
        res[0].last       = 1'b1;
        n_res             = 2'd1;
      end
    end

    cnt_d = cnt_q + QueCntW'(n_res) - QueCntW'(out_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
      phase_q     <= PhWait;
      bn_q        <= '0;
      off_q       <= '0;
      crc_q       <= '0;
      abort_q     <= 1'b0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        file_size_q <= cfg_data_i;
      end
      phase_q  <= phase_d;
      bn_q     <= bn_d;
      off_q    <= off_d;
      crc_q    <= crc_d;
      abort_q  <= abort_d;
      wr_ptr_q <= wr_ptr_q + QuePtrW'(n_res);
      rd_ptr_q <= rd_ptr_q + QuePtrW'(out_fire);
      cnt_q    <= cnt_d;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (QueCntW'(k) < QueCntW'(n_res)) begin
        que_q[wr_ptr_q + QuePtrW'(k)] <= res[k];
      end
    end
  end

endmodule

FILE: hw/rtl/xm1k_checker.sv
// xm1k_checker: port-level assertions for the xmodem-1k sender
// depends on xm1k_pkg; bound to xmodem_1k_crc_sender_top below

module xm1k_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input xm1k_pkg::out_word_t            out_word_o
);

  import xm1k_pkg::*;

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word dropped while stalled");

  // no fetch address without a fetch request
  a_fetch_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.fetch_valid |-> out_word_o.fetch_address == '0)
    else $error("fetch address set without request");

  // abort word carries nothing to send and closes the word's results
  a_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.event_code == EvAbort
      |-> !out_word_o.tx_valid && out_word_o.tx_byte == 8'h00 && out_word_o.last)
    else $error("malformed abort result");

  // eot carries the eot byte and no fetch request, and closes the word's results
  a_eot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.event_code == EvEot
      |-> out_word_o.tx_byte == ChEot && out_word_o.last && !out_word_o.fetch_valid)
    else $error("malformed eot result");

endmodule

bind xmodem_1k_crc_sender_top xm1k_checker u_xm1k_checker (.*);
